// ----- rtl/core/dbst_pkg.sv -----
// shared types, constants and control store for the deadband servo tracker
`timescale 1ns / 1ps
`default_nettype none

package dbst_pkg;

    // default parameter values
    localparam int POS_FRAC_BITS_DEF = 4;
    localparam int ANGLE_BITS_DEF    = 12;

    // fixed field widths
    localparam int POS_W    = 16;
    localparam int ANGLE_W  = 12;
    localparam int DB_W     = 16;
    localparam int GAIN_W   = 16;
    localparam int DIR_W    = 2;
    localparam int DIM_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // quotient bits produced by the serial divider, and its step counter
    localparam int QUOT_BITS = 16;
    localparam int CNT_W     = $clog2(QUOT_BITS);

    // product, rounding and step widths
    localparam int PROD_W    = DB_W + GAIN_W;
    localparam int RND_SHIFT = 23;
    localparam int RND_W     = PROD_W - RND_SHIFT;

    // saturation limits of the normalized offset magnitude
    localparam logic [DB_W-1:0] MAG_POS_MAX = 16'd32767;
    localparam logic [DB_W-1:0] MAG_NEG_MAX = 16'd32768;

    // register reset values
    localparam logic [ANGLE_W-1:0] ANGLE_LO_RST   = 12'd0;
    localparam logic [ANGLE_W-1:0] ANGLE_HI_RST   = 12'd180;
    localparam logic [DB_W-1:0]    DEADBAND_RST   = 16'd1638;
    localparam logic [GAIN_W-1:0]  GAIN_RST       = 16'd5120;
    localparam logic [DIR_W-1:0]   DIRECTION_RST  = 2'b01;
    localparam logic [ANGLE_W-1:0] STEP_LIMIT_RST = 12'd5;
    localparam logic [DIM_W-1:0]   IMAGE_DIM_RST  = 12'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_LO   = 3'd0,
        CFG_ANGLE_HI   = 3'd1,
        CFG_DEADBAND   = 3'd2,
        CFG_GAIN       = 3'd3,
        CFG_DIRECTION  = 3'd4,
        CFG_STEP_LIMIT = 3'd5,
        CFG_IMAGE_DIM  = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_MOVED     = 2'd0,
        ST_DEADBAND  = 2'd1,
        ST_NO_CHANGE = 2'd2,
        ST_BAD_CFG   = 2'd3
    } status_t;

    // control store addresses
    typedef enum logic [2:0] {
        PC_IDLE  = 3'd0,
        PC_PREP  = 3'd1,
        PC_DIV   = 3'd2,
        PC_SAT   = 3'd3,
        PC_MUL   = 3'd4,
        PC_STEP  = 3'd5,
        PC_ADD   = 3'd6,
        PC_WRITE = 3'd7
    } pc_t;

    // datapath operation of one control word
    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_PREP = 3'd1,
        OP_DIV  = 3'd2,
        OP_SAT  = 3'd3,
        OP_MUL  = 3'd4,
        OP_STEP = 3'd5,
        OP_ADD  = 3'd6,
        OP_EMIT = 3'd7
    } op_t;

    // sequencing condition of one control word
    typedef enum logic [2:0] {
        CND_NEXT     = 3'd0,
        CND_WAIT_IN  = 3'd1,
        CND_IF_BAD   = 3'd2,
        CND_LOOP     = 3'd3,
        CND_IF_HOLD  = 3'd4,
        CND_WAIT_OUT = 3'd5
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    // the program: one control word per step
    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t w;
        case (pc)
            PC_IDLE:  w = '{op: OP_LOAD, cond: CND_WAIT_IN,  target: PC_PREP};
            PC_PREP:  w = '{op: OP_PREP, cond: CND_IF_BAD,   target: PC_WRITE};
            PC_DIV:   w = '{op: OP_DIV,  cond: CND_LOOP,     target: PC_DIV};
            PC_SAT:   w = '{op: OP_SAT,  cond: CND_IF_HOLD,  target: PC_WRITE};
            PC_MUL:   w = '{op: OP_MUL,  cond: CND_NEXT,     target: PC_STEP};
            PC_STEP:  w = '{op: OP_STEP, cond: CND_NEXT,     target: PC_ADD};
            PC_ADD:   w = '{op: OP_ADD,  cond: CND_NEXT,     target: PC_WRITE};
            PC_WRITE: w = '{op: OP_EMIT, cond: CND_WAIT_OUT, target: PC_IDLE};
            default:  w = '{op: OP_LOAD, cond: CND_WAIT_IN,  target: PC_PREP};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/deadband_servo_tracker_step.sv -----
// deadband servo tracker: one proportional tracking step per target position
`timescale 1ns / 1ps
`default_nettype none

// One word in, one word out. Each input word is a target position (pixels,
// POS_FRAC_BITS fraction bits). The block forms the signed offset from the
// image centre as (pos - dim)/dim in Q1.15, truncated toward zero and
// saturated, holds the angle while its magnitude is below the deadband, and
// otherwise scales it by gain and direction, rounds half away from zero,
// limits the step to +-step_limit and adds it to the kept angle, clamped to
// [angle_lo, angle_hi]. A zero image size or angle_hi below angle_lo
// holds the angle and reports status 3. Control is a small microprogram
// (eight control words) stepping a shared datapath; the serial divider
// takes one quotient bit per cycle. A word runs through prep, 16 divide
// steps, saturate, multiply, step, add and write; a bad-configuration
// hold jumps from prep to write and a deadband hold from saturate. The
// next input word can be taken the cycle after the result is loaded into
// the output register, so one word is in flight at a time, and a stalled
// output holds the block in write. Configuration is accepted every cycle
// and must only be written while no word is in flight.
module deadband_servo_tracker_step #(
    parameter int POS_FRAC_BITS = dbst_pkg::POS_FRAC_BITS_DEF,
    parameter int ANGLE_BITS    = dbst_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [dbst_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dbst_pkg::CFG_DATA_W-1:0]     cfg_data,

    // input word
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [dbst_pkg::POS_W-1:0]          s_tdata,   // [15:0] target_pos

    // result word
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [15:0]                              m_tdata,   // [11:0] angle, [15:12] zero
    output logic [2:0]                               m_tuser    // [0] changed, [2:1] status
);

    // angle storage width: the port field is 12 bits wide
    localparam int AW = (ANGLE_BITS < dbst_pkg::ANGLE_W) ? ANGLE_BITS : dbst_pkg::ANGLE_W;
    // width of 2*pos - dim*2^(F+1), signed
    localparam int DW = (((dbst_pkg::POS_W + 1) > (dbst_pkg::DIM_W + POS_FRAC_BITS + 1))
                        ? (dbst_pkg::POS_W + 1)
                        : (dbst_pkg::DIM_W + POS_FRAC_BITS + 1)) + 1;
    // numerator after scaling by 2^(14-F)
    localparam int NSH   = 14 - POS_FRAC_BITS;
    localparam int NUM_W = DW + NSH;
    localparam int QB    = dbst_pkg::QUOT_BITS;
    localparam int HW    = NUM_W - QB;

    // configuration registers
    logic [AW-1:0]                  angle_lo_reg;
    logic [AW-1:0]                  angle_hi_reg;
    logic [dbst_pkg::DB_W-1:0]      deadband_reg;
    logic [dbst_pkg::GAIN_W-1:0]    gain_reg;
    logic [dbst_pkg::DIR_W-1:0]     direction_reg;
    logic [AW-1:0]                  step_limit_reg;
    logic [dbst_pkg::DIM_W-1:0]     image_dim_reg;

    // sequencer
    dbst_pkg::pc_t                  pc_reg, pc_next;
    dbst_pkg::ctrl_t                ctrl;
    logic [dbst_pkg::CNT_W-1:0]     cnt_reg, cnt_next;

    // datapath
    logic [dbst_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic                           neg_reg, neg_next;
    logic                           ovf_reg, ovf_next;
    logic [dbst_pkg::DIM_W-1:0]     rem_reg, rem_next;
    logic [QB-1:0]                  qs_reg, qs_next;
    logic [dbst_pkg::DB_W-1:0]      mag_reg, mag_next;
    logic [dbst_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic [AW-1:0]                  dmag_reg, dmag_next;
    logic                           dneg_reg, dneg_next;
    logic [AW-1:0]                  cur_reg, cur_next;

    // pending result
    logic [AW-1:0]                  res_angle_reg, res_angle_next;
    logic                           res_changed_reg, res_changed_next;
    dbst_pkg::status_t              res_status_reg, res_status_next;

    // output register
    logic                           m_valid_reg, m_valid_next;
    logic [dbst_pkg::ANGLE_W-1:0]   out_angle_reg, out_angle_next;
    logic                           out_changed_reg, out_changed_next;
    dbst_pkg::status_t              out_status_reg, out_status_next;

    // combinational helpers
    logic                           bad_cfg;
    logic                           out_free;
    logic signed [DW-1:0]           diff;
    logic signed [NUM_W-1:0]        num;
    logic [NUM_W-1:0]               abs_num;
    logic [dbst_pkg::DIM_W:0]       trial;
    logic                           trial_ge;
    logic [dbst_pkg::DB_W-1:0]      mag_cap;
    logic [dbst_pkg::DB_W-1:0]      mag_w;
    logic [dbst_pkg::PROD_W-1:0]    rnd_sum;
    logic [dbst_pkg::RND_W-1:0]     rnd;
    logic signed [AW+1:0]           dstep;
    logic signed [AW+1:0]           cand;
    logic [AW-1:0]                  new_angle;

    assign cfg_ready = 1'b1;
    assign ctrl      = dbst_pkg::ucode(pc_reg);
    assign s_tready  = (ctrl.cond == dbst_pkg::CND_WAIT_IN);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'b0000, out_angle_reg};
    assign m_tuser   = {out_status_reg, out_changed_reg};

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_lo_reg   <= AW'(dbst_pkg::ANGLE_LO_RST);
            angle_hi_reg   <= AW'(dbst_pkg::ANGLE_HI_RST);
            deadband_reg   <= dbst_pkg::DEADBAND_RST;
            gain_reg       <= dbst_pkg::GAIN_RST;
            direction_reg  <= dbst_pkg::DIRECTION_RST;
            step_limit_reg <= AW'(dbst_pkg::STEP_LIMIT_RST);
            image_dim_reg  <= dbst_pkg::IMAGE_DIM_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (dbst_pkg::cfg_idx_t'(cfg_index))
                dbst_pkg::CFG_ANGLE_LO:   angle_lo_reg   <= cfg_data[AW-1:0];
                dbst_pkg::CFG_ANGLE_HI:   angle_hi_reg   <= cfg_data[AW-1:0];
                dbst_pkg::CFG_DEADBAND:   deadband_reg   <= cfg_data;
                dbst_pkg::CFG_GAIN:       gain_reg       <= cfg_data;
                dbst_pkg::CFG_DIRECTION:  direction_reg  <= cfg_data[dbst_pkg::DIR_W-1:0];
                dbst_pkg::CFG_STEP_LIMIT: step_limit_reg <= cfg_data[AW-1:0];
                dbst_pkg::CFG_IMAGE_DIM:  image_dim_reg  <= cfg_data[dbst_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= dbst_pkg::PC_IDLE;
            cnt_reg     <= '0;
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            cnt_reg     <= cnt_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        pos_reg         <= pos_next;
        neg_reg         <= neg_next;
        ovf_reg         <= ovf_next;
        rem_reg         <= rem_next;
        qs_reg          <= qs_next;
        mag_reg         <= mag_next;
        prod_reg        <= prod_next;
        dmag_reg        <= dmag_next;
        dneg_reg        <= dneg_next;
        res_angle_reg   <= res_angle_next;
        res_changed_reg <= res_changed_next;
        res_status_reg  <= res_status_next;
        out_angle_reg   <= out_angle_next;
        out_changed_reg <= out_changed_next;
        out_status_reg  <= out_status_next;
    end

    always_comb begin
        // defaults: hold everything
        pc_next          = pc_reg;
        cnt_next         = cnt_reg;
        pos_next         = pos_reg;
        neg_next         = neg_reg;
        ovf_next         = ovf_reg;
        rem_next         = rem_reg;
        qs_next          = qs_reg;
        mag_next         = mag_reg;
        prod_next        = prod_reg;
        dmag_next        = dmag_reg;
        dneg_next        = dneg_reg;
        cur_next         = cur_reg;
        res_angle_next   = res_angle_reg;
        res_changed_next = res_changed_reg;
        res_status_next  = res_status_reg;
        out_angle_next   = out_angle_reg;
        out_changed_next = out_changed_reg;
        out_status_next  = out_status_reg;
        m_valid_next     = m_valid_reg && !m_tready;

        // zero image size comes before the limit check, both give the same hold
        bad_cfg  = (image_dim_reg == '0) || (angle_hi_reg < angle_lo_reg);
        out_free = !m_valid_reg || m_tready;

        // offset numerator: (2*pos - dim*2^(F+1)) * 2^(14-F)
        diff    = signed'(DW'({pos_reg, 1'b0}))
                - signed'(DW'(image_dim_reg) << (POS_FRAC_BITS + 1));
        num     = NUM_W'(diff) <<< NSH;
        abs_num = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

        // one restoring divide step
        trial    = {rem_reg, qs_reg[QB-1]};
        trial_ge = (trial >= {1'b0, image_dim_reg});

        // truncated quotient saturated to Q1.15, magnitude kept
        mag_cap = neg_reg ? dbst_pkg::MAG_NEG_MAX : dbst_pkg::MAG_POS_MAX;
        mag_w   = (ovf_reg || (qs_reg > mag_cap)) ? mag_cap : qs_reg;

        // round half away: magnitude is rounded, sign applied afterwards
        rnd_sum = dbst_pkg::PROD_W'(prod_reg + (dbst_pkg::PROD_W'(1) << (dbst_pkg::RND_SHIFT - 1)));
        rnd     = rnd_sum[dbst_pkg::PROD_W-1:dbst_pkg::RND_SHIFT];

        // signed step added to the kept angle, then clamped to the limits
        dstep = signed'((AW+2)'(dmag_reg));
        if (dneg_reg) begin
            dstep = -dstep;
        end
        cand = signed'((AW+2)'(cur_reg)) + dstep;
        if (cand < signed'((AW+2)'(angle_lo_reg))) begin
            new_angle = angle_lo_reg;
        end else if (cand > signed'((AW+2)'(angle_hi_reg))) begin
            new_angle = angle_hi_reg;
        end else begin
            new_angle = cand[AW-1:0];
        end

        // datapath operation
        case (ctrl.op)
            dbst_pkg::OP_LOAD: begin
                if (s_tvalid) begin
                    pos_next = s_tdata;
                end
            end
            dbst_pkg::OP_PREP: begin
                neg_next = num[NUM_W-1];
                ovf_next = (abs_num[NUM_W-1:QB] >= HW'(image_dim_reg));
                rem_next = abs_num[QB +: dbst_pkg::DIM_W];
                qs_next  = abs_num[QB-1:0];
                cnt_next = dbst_pkg::CNT_W'(QB - 1);
                if (bad_cfg) begin
                    res_angle_next   = cur_reg;
                    res_changed_next = 1'b0;
                    res_status_next  = dbst_pkg::ST_BAD_CFG;
                end
            end
            dbst_pkg::OP_DIV: begin
                rem_next = trial_ge ? dbst_pkg::DIM_W'(trial - {1'b0, image_dim_reg})
                                    : trial[dbst_pkg::DIM_W-1:0];
                qs_next  = {qs_reg[QB-2:0], trial_ge};
            end
            dbst_pkg::OP_SAT: begin
                mag_next = mag_w;
                if (mag_w < deadband_reg) begin
                    res_angle_next   = cur_reg;
                    res_changed_next = 1'b0;
                    res_status_next  = dbst_pkg::ST_DEADBAND;
                end
            end
            dbst_pkg::OP_MUL: begin
                prod_next = dbst_pkg::PROD_W'(mag_reg) * dbst_pkg::PROD_W'(gain_reg);
            end
            dbst_pkg::OP_STEP: begin
                // direction 0 gives no step; pattern 2'b10 acts as -1
                if (direction_reg == '0) begin
                    dmag_next = '0;
                end else if (16'(rnd) > 16'(step_limit_reg)) begin
                    dmag_next = step_limit_reg;
                end else begin
                    dmag_next = AW'(rnd);
                end
                dneg_next = neg_reg ^ direction_reg[dbst_pkg::DIR_W-1];
            end
            dbst_pkg::OP_ADD: begin
                res_angle_next = new_angle;
                if (new_angle == cur_reg) begin
                    res_changed_next = 1'b0;
                    res_status_next  = dbst_pkg::ST_NO_CHANGE;
                end else begin
                    res_changed_next = 1'b1;
                    res_status_next  = dbst_pkg::ST_MOVED;
                    cur_next         = new_angle;
                end
            end
            dbst_pkg::OP_EMIT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    out_angle_next   = dbst_pkg::ANGLE_W'(res_angle_reg);
                    out_changed_next = res_changed_reg;
                    out_status_next  = res_status_reg;
                end
            end
            default: ;
        endcase

        // sequencing
        case (ctrl.cond)
            dbst_pkg::CND_NEXT: begin
                pc_next = dbst_pkg::pc_t'(3'(pc_reg + 3'd1));
            end
            dbst_pkg::CND_WAIT_IN: begin
                if (s_tvalid) begin
                    pc_next = ctrl.target;
                end
            end
            dbst_pkg::CND_IF_BAD: begin
                pc_next = bad_cfg ? ctrl.target : dbst_pkg::pc_t'(3'(pc_reg + 3'd1));
            end
            dbst_pkg::CND_LOOP: begin
                if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - dbst_pkg::CNT_W'(1);
                    pc_next  = ctrl.target;
                end else begin
                    pc_next  = dbst_pkg::pc_t'(3'(pc_reg + 3'd1));
                end
            end
            dbst_pkg::CND_IF_HOLD: begin
                pc_next = (mag_w < deadband_reg) ? ctrl.target
                                                 : dbst_pkg::pc_t'(3'(pc_reg + 3'd1));
            end
            dbst_pkg::CND_WAIT_OUT: begin
                if (out_free) begin
                    pc_next = ctrl.target;
                end
            end
            default: begin
                pc_next = dbst_pkg::PC_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// self-checking testbench for the deadband servo tracker step block
`timescale 1ns / 1ps

module testbench;
    import dbst_pkg::*;

    // index with no register behind it, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    // extra wait after the last expected word has arrived, so the block goes idle
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_PRINTED   = 40;

    // one expected result word, with the position that caused it
    typedef struct {
        logic [15:0]        pos;
        logic [ANGLE_W-1:0] angle;
        logic               changed;
        status_t            status;
    } tracker_result_t;

    logic aclk = 1'b0;
    logic aresetn;

    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic             s_tvalid;
    logic             s_tready;
    logic [POS_W-1:0] s_tdata;     // [15:0] target_pos

    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;          // [11:0] angle, [15:12] zero
    logic [2:0]  m_tuser;          // [0] changed, [2:1] status

    // shadow of the configuration and the kept angle
    logic [ANGLE_W-1:0] min_reg;
    logic [ANGLE_W-1:0] max_reg;
    logic [DB_W-1:0]    deadband_reg;
    logic [GAIN_W-1:0]  gain_reg;
    int                 dir_sign;
    logic [ANGLE_W-1:0] step_reg;
    logic [DIM_W-1:0]   dim_reg;
    logic [ANGLE_W-1:0] kept_angle;

    tracker_result_t expected_moves[$];
    tracker_result_t checked_move;
    int              mismatch_count = 0;

    // idling percentage shared by sender and receiver
    int idle_pct     = 30;
    int hold_request = 0;
    int hold_left    = 0;

    deadband_servo_tracker_step dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 aclk = ~aclk;

    // ---------------------------------------------------------------
    // tracker prediction
    // ---------------------------------------------------------------

    task automatic reset_tracker_shadow();
        min_reg      = ANGLE_LO_RST;
        max_reg      = ANGLE_HI_RST;
        deadband_reg = DEADBAND_RST;
        gain_reg     = GAIN_RST;
        dir_sign     = 1;
        step_reg     = STEP_LIMIT_RST;
        dim_reg      = IMAGE_DIM_RST;
        kept_angle   = '0;
    endtask

    // one tracking step: works out the result word and moves the kept angle
    function automatic tracker_result_t track_step(input logic [15:0] pos);
        tracker_result_t r;
        longint dim, num, norm, mag, delta, limit, cand;
        r.pos     = pos;
        r.angle   = kept_angle;
        r.changed = 1'b0;
        // size check first, then the limit check
        if (dim_reg == 0 || max_reg < min_reg) begin
            r.status = ST_BAD_CFG;
            return r;
        end
        dim  = longint'(dim_reg);
        num  = 2 * longint'(pos) - dim * (64'sd1 << (POS_FRAC_BITS_DEF + 1));
        num  = num * (64'sd1 << (14 - POS_FRAC_BITS_DEF));
        norm = num / dim;                  // truncates toward zero
        if (norm > 32767)
            norm = 32767;
        if (norm < -32768)
            norm = -32768;
        mag = (norm < 0) ? -norm : norm;
        if (mag < longint'(deadband_reg)) begin
            r.status = ST_DEADBAND;
            return r;
        end
        // round half away from zero on the magnitude, then apply the sign
        delta = (mag * longint'(gain_reg) + (64'sd1 << 22)) >>> 23;
        if ((norm < 0) != (dir_sign < 0))
            delta = -delta;
        if (dir_sign == 0)
            delta = 0;
        limit = longint'(step_reg);
        if (delta > limit)
            delta = limit;
        if (delta < -limit)
            delta = -limit;
        cand = longint'(kept_angle) + delta;
        if (cand < longint'(min_reg))
            cand = longint'(min_reg);
        if (cand > longint'(max_reg))
            cand = longint'(max_reg);
        if (cand == longint'(kept_angle)) begin
            r.status = ST_NO_CHANGE;
            return r;
        end
        kept_angle = cand[ANGLE_W-1:0];
        r.angle    = kept_angle;
        r.changed  = 1'b1;
        r.status   = ST_MOVED;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // registers are only written once every word has come back out
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_moves.size() != 0)
            @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_ANGLE_LO:   min_reg = v[ANGLE_W-1:0];
            CFG_ANGLE_HI:   max_reg = v[ANGLE_W-1:0];
            CFG_DEADBAND:   deadband_reg = v;
            CFG_GAIN:       gain_reg = v;
            CFG_DIRECTION:  dir_sign = v[1] ? -1 : int'(v[0]);   // pattern 2'b10 acts as -1
            CFG_STEP_LIMIT: step_reg = v[ANGLE_W-1:0];
            CFG_IMAGE_DIM:  dim_reg = v[DIM_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // offers one position word; valid stays high afterwards so that the
    // next word can follow back to back
    task automatic send_pos(input logic [15:0] pos);
        @(negedge aclk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = pos;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_moves.push_back(track_step(pos));
    endtask

    // lets every expected word arrive and the block go idle
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_moves.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // position around the image centre, sometimes anywhere in the field
    function automatic logic [15:0] pick_pos();
        int centre, p;
        if (dim_reg == 0 || $urandom_range(0, 99) < 20)
            return 16'($urandom);
        centre = 16 * int'(dim_reg);
        p = int'($urandom_range(0, 2 * centre));
        if (p > 65535)
            p = 65535;
        return 16'(p);
    endfunction

    // random setting of every register, extremes included
    task automatic randomize_setup();
        int lo, hi, pick, v;
        pick = $urandom_range(0, 99);
        lo = (pick < 10) ? 0 : (pick < 15) ? 4095 : $urandom_range(0, 2000);
        if (lo > 0 && $urandom_range(0, 99) < 8)
            hi = $urandom_range(0, lo - 1);          // bad limits
        else if ($urandom_range(0, 99) < 15)
            hi = 4095;
        else
            hi = $urandom_range(lo, 4095);
        write_reg(CFG_ANGLE_LO, {4'($urandom), 12'(lo)});
        write_reg(CFG_ANGLE_HI, {4'($urandom), 12'(hi)});

        pick = $urandom_range(0, 99);
        v = (pick < 20) ? 0 : (pick < 30) ? 32768 : (pick < 40) ? int'($urandom_range(0, 65535)) :
            (pick < 80) ? int'($urandom_range(0, 2000)) : int'($urandom_range(0, 32768));
        write_reg(CFG_DEADBAND, 16'(v));

        pick = $urandom_range(0, 99);
        v = (pick < 8) ? 0 : (pick < 16) ? 65535 : (pick < 60) ? int'($urandom_range(256, 8192)) :
            int'($urandom_range(0, 65535));
        write_reg(CFG_GAIN, 16'(v));

        write_reg(CFG_DIRECTION, 16'($urandom));

        pick = $urandom_range(0, 99);
        v = (pick < 8) ? 0 : (pick < 16) ? 4095 : (pick < 50) ? int'($urandom_range(1, 8)) :
            (pick < 80) ? int'($urandom_range(1, 300)) : int'($urandom_range(0, 4095));
        write_reg(CFG_STEP_LIMIT, {4'($urandom), 12'(v)});

        pick = $urandom_range(0, 99);
        v = (pick < 4) ? 0 : (pick < 9) ? 1 : (pick < 14) ? 4095 : int'($urandom_range(100, 4095));
        write_reg(CFG_IMAGE_DIM, {4'($urandom), 12'(v)});

        if ($urandom_range(0, 9) == 0)
            write_reg(CFG_UNUSED, 16'($urandom));
    endtask

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_tready  = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready = ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want,
                                   input logic [15:0] pos);
        if (mismatch_count < MAX_PRINTED)
            $display("mismatch %s: got %0d expected %0d (pos %0d) at %0t",
                     what, got, want, pos, $realtime);
        mismatch_count++;
    endtask

    // each result word against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_moves.size() == 0) begin
                report_mismatch("unexpected word", int'(m_tdata), 0, 16'd0);
            end else begin
                checked_move = expected_moves.pop_front();
                if (m_tdata[ANGLE_W-1:0] !== checked_move.angle)
                    report_mismatch("angle", int'(m_tdata[ANGLE_W-1:0]),
                                    int'(checked_move.angle), checked_move.pos);
                if (m_tdata[15:ANGLE_W] !== '0)
                    report_mismatch("tdata padding", int'(m_tdata[15:ANGLE_W]), 0,
                                    checked_move.pos);
                if (m_tuser[0] !== checked_move.changed)
                    report_mismatch("changed", int'(m_tuser[0]), int'(checked_move.changed),
                                    checked_move.pos);
                if (m_tuser[2:1] !== checked_move.status)
                    report_mismatch("status", int'(m_tuser[2:1]), int'(checked_move.status),
                                    checked_move.pos);
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset settings: centre hold, saturated offsets, clamp at the lower limit
    task automatic test_reset_defaults();
        send_pos(16'd10240);     // image centre, inside the deadband
        send_pos(16'hFFFF);      // offset far outside Q1.15, saturates
        send_pos(16'd0);         // full negative offset
        send_pos(16'd0);         // already at the lower limit, no change
        send_pos(16'd15360);     // half offset, step limited to the step limit
        settle();
    endtask

    // zero image size and max below min both hold with a bad status
    task automatic test_bad_configuration();
        write_reg(CFG_IMAGE_DIM, 16'd0);
        send_pos(16'hFFFF);
        write_reg(CFG_ANGLE_LO, 16'd100);
        write_reg(CFG_ANGLE_HI, 16'd50);
        send_pos(16'd0);         // both faults at once
        write_reg(CFG_IMAGE_DIM, 16'd640);
        send_pos(16'hFFFF);      // bad limits alone
        settle();
    endtask

    // exact halves round away from zero; every direction pattern
    task automatic test_rounding_and_direction();
        write_reg(CFG_ANGLE_LO, 16'd0);
        write_reg(CFG_ANGLE_HI, 16'd4095);
        write_reg(CFG_STEP_LIMIT, 16'd4095);
        write_reg(CFG_GAIN, 16'd256);
        write_reg(CFG_DEADBAND, 16'd0);
        write_reg(CFG_DIRECTION, 16'h0001);
        send_pos(16'd15360);     // +0.5 rounds to +1
        send_pos(16'd5120);      // -0.5 rounds to -1
        send_pos(16'd10240);     // zero offset with zero deadband: no change
        write_reg(CFG_GAIN, 16'hFFFF);
        send_pos(16'hFFFF);
        write_reg(CFG_DIRECTION, 16'h0002);   // the -2 pattern acts as -1
        send_pos(16'hFFFF);
        write_reg(CFG_DIRECTION, 16'h0000);   // zero direction, zero step
        send_pos(16'hFFFF);
        write_reg(CFG_DIRECTION, 16'h0003);
        send_pos(16'd0);
        settle();
    endtask

    // step limit, deadband and image size at their ends
    task automatic test_field_extremes();
        write_reg(CFG_STEP_LIMIT, 16'd0);
        send_pos(16'd0);
        write_reg(CFG_STEP_LIMIT, 16'hFFFF);  // upper bits dropped, 4095
        write_reg(CFG_DEADBAND, 16'h8000);
        send_pos(16'd0);         // magnitude 32768 passes the deadband
        send_pos(16'hFFFF);      // magnitude 32767 is held
        write_reg(CFG_DEADBAND, 16'hFFFF);
        send_pos(16'd0);
        write_reg(CFG_DEADBAND, 16'd0);
        write_reg(CFG_IMAGE_DIM, 16'd1);
        send_pos(16'd0);
        send_pos(16'hFFFF);
        send_pos(16'd16);        // centre of a one pixel image
        write_reg(CFG_IMAGE_DIM, 16'hFFFF);   // 4095 after masking
        send_pos(16'd0);
        send_pos(16'hFFFF);
        settle();
    endtask

    // kept angle outside fresh limits is pulled back inside
    task automatic test_angle_limits();
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_ANGLE_HI, 16'd100);
        send_pos(16'd0);
        write_reg(CFG_ANGLE_HI, 16'd300);
        write_reg(CFG_ANGLE_LO, 16'd200);
        send_pos(16'hFFFF);
        write_reg(CFG_ANGLE_HI, 16'd4095);
        write_reg(CFG_ANGLE_LO, 16'd4095);
        send_pos(16'hFFFF);
        settle();
    endtask

    // many random settings, random positions around the centre
    task automatic test_random_sweeps(input int phases, input int per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            randomize_setup();
            repeat (per_phase) send_pos(pick_pos());
            settle();
        end
    endtask

    // back to back words, neither side idles
    task automatic test_no_idle_stretch();
        randomize_setup();
        idle_pct = 0;
        repeat (300) send_pos(pick_pos());
        settle();
        idle_pct = 30;
    endtask

    // long receiver hold-off while the sender keeps offering words
    task automatic test_output_backpressure();
        for (int k = 0; k < 2; k++) begin
            randomize_setup();
            @(posedge aclk);
            hold_request = 400;
            repeat (40) send_pos(pick_pos());
            settle();
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        reset_tracker_shadow();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_bad_configuration();
        test_rounding_and_direction();
        test_field_extremes();
        test_angle_limits();
        test_random_sweeps(13, 100);
        test_no_idle_stretch();
        test_output_backpressure();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
